@@ hw/rtl/sitc_pkg.sv @@
package sitc_pkg;

  localparam int SIDE_W  = 15;
  localparam int POS_W   = 30;
  localparam int COORD_W = 15;

  // square root of a POS_W radicand gives ROOT_W result bits, one per step
  localparam int ROOT_W  = POS_W / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int TRIAL_W = REM_W + 2;
  localparam int CNT_W   = $clog2(ROOT_W);

  // ring size and coordinate arithmetic widths
  localparam int RING_W  = ROOT_W + 1;
  localparam int CALC_W  = RING_W + 1;
  localparam int SQ_W    = 2 * RING_W;

  localparam logic [SIDE_W:0] MAX_SIDE = (SIDE_W + 1)'(32767);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CHECK,
    ST_ROOT,
    ST_RING,
    ST_BASE,
    ST_LIMITS,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_rsp_t;

endpackage

@@ hw/rtl/sitc_root.sv @@
module sitc_root (
  input  logic                clk,
  input  logic                rst,
  input  sitc_pkg::root_req_t req,
  output sitc_pkg::root_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [sitc_pkg::CNT_W-1:0]    cnt;
  logic [sitc_pkg::RAD_W-1:0]    rad;
  logic [sitc_pkg::REM_W-1:0]    rem;
  logic [sitc_pkg::ROOT_W-1:0]   root;

  logic [sitc_pkg::TRIAL_W-1:0]  trial;
  logic [sitc_pkg::TRIAL_W-1:0]  test;
  logic [sitc_pkg::TRIAL_W-1:0]  diff;
  logic                          fits;

  // one result bit per cycle: bring down two radicand bits, try 4*root+1
  always_comb begin
    trial = {rem, rad[sitc_pkg::RAD_W-1 -: 2]};
    test  = {(sitc_pkg::TRIAL_W - sitc_pkg::ROOT_W - 2)'(0), root, 2'b01};
    fits  = trial >= test;
    diff  = trial - test;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + sitc_pkg::CNT_W'(1);
        if (cnt == sitc_pkg::CNT_W'(sitc_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? diff[sitc_pkg::REM_W-1:0] : trial[sitc_pkg::REM_W-1:0];
      root <= {root[sitc_pkg::ROOT_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

@@ hw/rtl/spiral_index_to_coordinate.sv @@
// channel   handshake            beat payload
// input     in_valid / in_stall  grid_side, position
// output    out_valid / out_stall line, column, bad_request
//
// a good request passes the square, check, root, ring, base and limits states
// before delivery; the 15-step square root unit is the longest of these
// a bad request goes from the check state straight to the output register
// rst is synchronous; it clears the sequencer, the root unit and out_valid
// one item at a time; the next item is taken while a result waits on out_stall
module spiral_index_to_coordinate (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sitc_pkg::SIDE_W-1:0]  grid_side,
  input  logic [sitc_pkg::POS_W-1:0]   position,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sitc_pkg::COORD_W-1:0] line,
  output logic [sitc_pkg::COORD_W-1:0] column,
  output logic                         bad_request
);

  sitc_pkg::state_t state, state_next;

  sitc_pkg::root_req_t root_req;
  sitc_pkg::root_rsp_t root_rsp;

  logic [sitc_pkg::SIDE_W-1:0] side;
  logic [sitc_pkg::POS_W-1:0]  k;
  logic [sitc_pkg::POS_W-1:0]  sq;
  logic                        bad;
  logic                        bad_next;

  logic [sitc_pkg::RING_W-1:0] s;
  logic [sitc_pkg::RING_W-1:0] s1;
  logic [sitc_pkg::RING_W-1:0] s_m2;
  logic [sitc_pkg::RING_W-1:0] s_inc;
  logic [sitc_pkg::RING_W-1:0] s_next;
  logic [sitc_pkg::CALC_W-1:0] sum;
  logic [sitc_pkg::SQ_W-1:0]   base;
  logic [sitc_pkg::SQ_W-1:0]   offs_full;
  logic [sitc_pkg::CALC_W-1:0] big;
  logic [sitc_pkg::CALC_W-1:0] little;
  logic [sitc_pkg::CALC_W-1:0] half;
  logic [sitc_pkg::CALC_W-1:0] s1_ext;
  logic [sitc_pkg::CALC_W-1:0] two_s1;
  logic [sitc_pkg::CALC_W-1:0] three_s1;
  logic [sitc_pkg::CALC_W-1:0] t;
  logic [sitc_pkg::CALC_W-1:0] bs1;
  logic [sitc_pkg::CALC_W-1:0] sm2;
  logic [sitc_pkg::CALC_W-1:0] sm3;

  logic [sitc_pkg::CALC_W-1:0] line_calc;
  logic [sitc_pkg::CALC_W-1:0] col_calc;
  logic                        load;

  sitc_root u_root (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sitc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    bad_next = !side[0] || ({1'b0, side} > sitc_pkg::MAX_SIDE) ||
               (k == '0) || (k > sq);
  end

  always_comb begin
    state_next        = state;
    in_stall          = 1'b1;
    root_req.start    = 1'b0;
    root_req.radicand = k - sitc_pkg::POS_W'(1);
    load              = 1'b0;
    case (state)
      sitc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = sitc_pkg::ST_SQUARE;
        end
      end
      sitc_pkg::ST_SQUARE: begin
        state_next = sitc_pkg::ST_CHECK;
      end
      sitc_pkg::ST_CHECK: begin
        if (bad_next) begin
          state_next = sitc_pkg::ST_DELIVER;
        end else begin
          root_req.start = 1'b1;
          state_next     = sitc_pkg::ST_ROOT;
        end
      end
      sitc_pkg::ST_ROOT: begin
        if (root_rsp.done) begin
          state_next = sitc_pkg::ST_RING;
        end
      end
      sitc_pkg::ST_RING: begin
        state_next = sitc_pkg::ST_BASE;
      end
      sitc_pkg::ST_BASE: begin
        state_next = sitc_pkg::ST_LIMITS;
      end
      sitc_pkg::ST_LIMITS: begin
        state_next = sitc_pkg::ST_DELIVER;
      end
      sitc_pkg::ST_DELIVER: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = sitc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sitc_pkg::ST_IDLE;
      end
    endcase
  end

  // smallest odd ring whose square covers the position
  always_comb begin
    s_inc  = sitc_pkg::RING_W'(root_rsp.root) + sitc_pkg::RING_W'(1);
    s_next = s_inc | sitc_pkg::RING_W'(1);
    half   = sum >> 1;
    s1_ext = sitc_pkg::CALC_W'(s1);
    offs_full = {(sitc_pkg::SQ_W - sitc_pkg::POS_W)'(0), k} - base;
  end

  always_ff @(posedge clk) begin
    case (state)
      sitc_pkg::ST_IDLE: begin
        side <= grid_side;
        k    <= position;
      end
      sitc_pkg::ST_SQUARE: begin
        sq <= sitc_pkg::POS_W'(side) * sitc_pkg::POS_W'(side);
      end
      sitc_pkg::ST_CHECK: begin
        bad <= bad_next;
      end
      sitc_pkg::ST_RING: begin
        s    <= s_next;
        s1   <= s_next - sitc_pkg::RING_W'(1);
        s_m2 <= s_next - sitc_pkg::RING_W'(2);
        sum  <= sitc_pkg::CALC_W'(side) + sitc_pkg::CALC_W'(s_next);
      end
      sitc_pkg::ST_BASE: begin
        base     <= sitc_pkg::SQ_W'(s_m2) * sitc_pkg::SQ_W'(s_m2);
        big      <= half;
        little   <= half - s1_ext;
        two_s1   <= s1_ext << 1;
        three_s1 <= s1_ext + (s1_ext << 1);
      end
      sitc_pkg::ST_LIMITS: begin
        t   <= offs_full[sitc_pkg::CALC_W-1:0];
        bs1 <= big + s1_ext;
        sm2 <= little - two_s1;
        sm3 <= little - three_s1;
      end
      default: begin
      end
    endcase
  end

  // walk the four sides of the ring: bottom line, left column, top line, right column
  always_comb begin
    if (bad) begin
      line_calc = '0;
      col_calc  = '0;
    end else if (s == sitc_pkg::RING_W'(1)) begin
      line_calc = big;
      col_calc  = big;
    end else if (t <= s1_ext) begin
      line_calc = big;
      col_calc  = big - t;
    end else if (t <= two_s1) begin
      line_calc = bs1 - t;
      col_calc  = little;
    end else if (t <= three_s1) begin
      line_calc = little;
      col_calc  = sm2 + t;
    end else begin
      line_calc = sm3 + t;
      col_calc  = big;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line        <= line_calc[sitc_pkg::COORD_W-1:0];
      column      <= col_calc[sitc_pkg::COORD_W-1:0];
      bad_request <= bad;
    end
  end

endmodule

@@ hw/rtl/sitc_checker.sv @@
module sitc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [sitc_pkg::COORD_W-1:0] line,
  input logic [sitc_pkg::COORD_W-1:0] column,
  input logic                         bad_request
);

  // a waiting beat is neither dropped nor altered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({line, column, bad_request}))
    else $error("output beat changed while stalled");

  // rejected requests carry zero coordinates
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_request |-> line == '0 && column == '0)
    else $error("bad request with nonzero coordinates");

  // answered requests land on the one-based grid
  a_good_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_request |-> line != '0 && column != '0)
    else $error("good request with zero coordinate");

  // the block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

endmodule

bind spiral_index_to_coordinate sitc_checker u_sitc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .line        (line),
  .column      (column),
  .bad_request (bad_request)
);

@@ tb/spiral_spot_monitor.sv @@
`timescale 1ns / 1ps

module spiral_spot_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [sitc_pkg::SIDE_W-1:0]  grid_side,
  input  logic [sitc_pkg::POS_W-1:0]   position,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [sitc_pkg::COORD_W-1:0] line,
  input  logic [sitc_pkg::COORD_W-1:0] column,
  input  logic                         bad_request,
  output int                           mismatches,
  output int                           answered,
  output int                           flagged,
  output int                           awaiting
);

  typedef struct packed {
    logic [sitc_pkg::SIDE_W-1:0]  side;
    logic [sitc_pkg::POS_W-1:0]   pos;
    logic [sitc_pkg::COORD_W-1:0] line;
    logic [sitc_pkg::COORD_W-1:0] column;
    logic                         bad;
  } spot_t;

  spot_t spots[$];

  initial begin
    mismatches = 0;
    answered   = 0;
    flagged    = 0;
    awaiting   = 0;
  end

  // where a sequence number lands on the grid
  function automatic spot_t locate(input logic [sitc_pkg::SIDE_W-1:0] side,
                                   input logic [sitc_pkg::POS_W-1:0]  pos);
    spot_t           spot;
    longint unsigned n, k, root, trial, ring, far, near, t, ln, col;
    int              b;
    spot      = '0;
    spot.side = side;
    spot.pos  = pos;
    n = side;
    k = pos;
    if (!side[0] || n > sitc_pkg::MAX_SIDE || k == 0 || k > n * n) begin
      spot.bad = 1'b1;
      return spot;
    end
    // floor root of k-1, then round up to the next odd ring
    root = 0;
    for (b = 14; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= k - 1) root = trial;
    end
    ring = root + 1;
    if (!ring[0]) ring = ring + 1;
    far  = (n + ring) / 2;
    near = far + 1 - ring;
    if (ring == 1) begin
      ln  = far;
      col = far;
    end else begin
      t = k - (ring - 2) * (ring - 2);
      if (t <= ring - 1) begin
        ln  = far;
        col = far - t;
      end else if (t <= 2 * ring - 2) begin
        ln  = far - (t - (ring - 1));
        col = near;
      end else if (t <= 3 * ring - 3) begin
        ln  = near;
        col = near + (t - (2 * ring - 2));
      end else begin
        ln  = near + (t - (3 * ring - 3));
        col = far;
      end
    end
    spot.line   = ln[sitc_pkg::COORD_W-1:0];
    spot.column = col[sitc_pkg::COORD_W-1:0];
    return spot;
  endfunction

  task automatic report_mismatch(input string what, input spot_t req, input int got,
                                 input int want);
    $display("monitor: %s for side %0d position %0d: got %0d, want %0d at %0t",
             what, req.side, req.pos, got, want, $realtime);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    spot_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (spots.size() == 0) begin
          report_mismatch("beat with nothing pending", '0, int'(line), 0);
        end else begin
          want = spots.pop_front();
          answered = answered + 1;
          if (want.bad) flagged = flagged + 1;
          if (line != want.line)
            report_mismatch("line", want, int'(line), int'(want.line));
          if (column != want.column)
            report_mismatch("column", want, int'(column), int'(want.column));
          if (bad_request !== want.bad)
            report_mismatch("bad_request", want, int'(bad_request), int'(want.bad));
        end
      end
      if (in_valid && !in_stall) spots.push_back(locate(grid_side, position));
    end
    awaiting = spots.size();
  end

endmodule

@@ tb/spiral_index_to_coordinate_test.sv @@
`timescale 1ns / 1ps

module spiral_index_to_coordinate_test;

  localparam int SIDE_W = sitc_pkg::SIDE_W;
  localparam int POS_W  = sitc_pkg::POS_W;

  logic                         clk;
  logic                         rst         = 1'b1;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic [SIDE_W-1:0]            grid_side   = '0;
  logic [POS_W-1:0]             position    = '0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic [sitc_pkg::COORD_W-1:0] line;
  logic [sitc_pkg::COORD_W-1:0] column;
  logic                         bad_request;
  logic                         steady      = 1'b0;

  int mismatches, answered, flagged, awaiting;

  spiral_index_to_coordinate DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .grid_side   (grid_side),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line        (line),
    .column      (column),
    .bad_request (bad_request)
  );

  spiral_spot_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .grid_side   (grid_side),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line        (line),
    .column      (column),
    .bad_request (bad_request),
    .mismatches  (mismatches),
    .answered    (answered),
    .flagged     (flagged),
    .awaiting    (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(0, 99) < 25);
  end

  task automatic send_beat(input logic [SIDE_W-1:0] side, input logic [POS_W-1:0] pos);
    grid_side <= side;
    position  <= pos;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // mostly good requests, biased toward ring corners, with some bad ones mixed in
  task automatic pick_request(output logic [SIDE_W-1:0] side, output logic [POS_W-1:0] pos);
    int unsigned n, area, ring, roll;
    int          t;
    roll = $urandom_range(0, 99);
    if (roll < 40) n = 2 * $urandom_range(0, 15) + 1;
    else if (roll < 75) n = 2 * $urandom_range(16, 511) + 1;
    else if (roll < 90) n = 2 * $urandom_range(512, 16383) + 1;
    else n = 32767 - 2 * $urandom_range(0, 1);
    area = n * n;
    side = SIDE_W'(n);
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      side = SIDE_W'(2 * $urandom_range(0, 16383));
      pos  = POS_W'($urandom);
    end else if (roll < 9) begin
      pos = '0;
    end else if (roll < 15) begin
      pos = POS_W'($urandom_range(area + 1, 2 ** 30 - 1));
    end else if (roll < 55) begin
      pos = POS_W'($urandom_range(1, area));
    end else begin
      ring = 2 * $urandom_range(0, (n - 1) / 2) + 1;
      if (ring == 1) begin
        pos = POS_W'(1);
      end else begin
        t = $urandom_range(0, 4) * (ring - 1) + $urandom_range(0, 2) - 1;
        if (t < 1) t = 1;
        if (t > 4 * (ring - 1)) t = 4 * (ring - 1);
        pos = POS_W'((ring - 2) * (ring - 2) + t);
      end
    end
  endtask

  initial begin
    logic [SIDE_W-1:0] side;
    logic [POS_W-1:0]  pos;
    int                i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_beat(15'd1, 30'd1);
    send_beat(15'd1, 30'd2);
    send_beat(15'd0, 30'd1);
    send_beat(15'd2, 30'd3);
    send_beat(15'd7, 30'd0);
    // every leg and corner of the first ring, then one past the grid
    for (i = 1; i <= 10; i++) send_beat(15'd3, POS_W'(i));
    send_beat(15'd5, 30'd17);
    send_beat(15'd5, 30'd25);
    send_beat(15'd32767, 30'd1);
    send_beat(15'd32767, 30'd1073610757);
    send_beat(15'd32767, 30'd1073676289);
    send_beat(15'd32767, 30'd1073676290);
    send_beat(15'd32767, 30'd1073741823);
    send_beat(15'd32767, 30'd536870912);
    send_beat(15'd32766, 30'd5);
    drain();

    for (i = 0; i < 1800; i++) begin
      steady <= (i >= 700 && i < 1000);
      if (i == 1200) drain();
      pick_request(side, pos);
      send_beat(side, pos);
    end
    steady <= 1'b0;
    drain();
    repeat (30) @(posedge clk);

    $display("covered %0d requests on grids up to side 32767, %0d of them rejected",
             answered, flagged);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
